### sv/ppct_pkg.sv
`default_nettype none
package ppct_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_STAGES = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOTTOM_X,
    REG_BOTTOM_Y,
    REG_BOTTOM_Z,
    REG_TOP_X,
    REG_TOP_Y,
    REG_TOP_Z,
    REG_RADIUS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_DIFF,
    CFG_SQ,
    CFG_ROOT,
    CFG_LSQ
  } cfg_state_t;

  typedef struct packed {
    logic busy;
    logic degenerate;
  } ppct_status_t;

endpackage
`default_nettype wire

### sv/ppct_if.sv
`default_nettype none
interface ppct_point_if #(
  parameter int COORD_WIDTH = ppct_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] pad_distance;

  modport source (
    output valid, point_x, point_y, point_z, pad_distance,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, pad_distance,
    output ready
  );
endinterface

interface ppct_result_if ();
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate_axis;

  modport source (
    output valid, inside_res, degenerate_axis,
    input  ready
  );
  modport sink (
    input  valid, inside_res, degenerate_axis,
    output ready
  );
endinterface
`default_nettype wire

### sv/ppct_mul.sv
`default_nettype none
module ppct_mul #(
  parameter int A_WIDTH    = ppct_pkg::COORD_WIDTH_DEF + 1,
  parameter int B_WIDTH    = ppct_pkg::COORD_WIDTH_DEF + 1,
  parameter bit SIGNED_OPS = 1'b1
) (
  input  logic                              clk,
  input  logic [ppct_pkg::MUL_STAGES-1:0]   en,
  input  logic [A_WIDTH-1:0]                a,
  input  logic [B_WIDTH-1:0]                b,
  output logic [A_WIDTH+B_WIDTH-1:0]        p
);
  import ppct_pkg::*;

  localparam int AL = A_WIDTH / 2;
  localparam int AH = A_WIDTH - AL;
  localparam int BL = B_WIDTH / 2;
  localparam int BH = B_WIDTH - BL;
  localparam int PW = A_WIDTH + B_WIDTH;

  logic                 a_neg;
  logic                 b_neg;
  logic [A_WIDTH-1:0]   mag_a;
  logic [B_WIDTH-1:0]   mag_b;
  logic                 neg1;
  logic [AL+BL-1:0]     pp_ll;
  logic [AL+BH-1:0]     pp_lh;
  logic [AH+BL-1:0]     pp_hl;
  logic [AH+BH-1:0]     pp_hh;
  logic                 neg2;
  logic [PW-1:0]        sum;
  logic                 neg3;

  assign a_neg = SIGNED_OPS & a[A_WIDTH-1];
  assign b_neg = SIGNED_OPS & b[B_WIDTH-1];

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_a <= a_neg ? (~a + A_WIDTH'(1)) : a;
      mag_b <= b_neg ? (~b + B_WIDTH'(1)) : b;
      neg1  <= a_neg ^ b_neg;
    end
  end

  // half-width partial products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pp_ll <= {{BL{1'b0}}, mag_a[AL-1:0]} * {{AL{1'b0}}, mag_b[BL-1:0]};
      pp_lh <= {{BH{1'b0}}, mag_a[AL-1:0]} * {{AL{1'b0}}, mag_b[B_WIDTH-1:BL]};
      pp_hl <= {{BL{1'b0}}, mag_a[A_WIDTH-1:AL]} * {{AH{1'b0}}, mag_b[BL-1:0]};
      pp_hh <= {{BH{1'b0}}, mag_a[A_WIDTH-1:AL]} * {{AH{1'b0}}, mag_b[B_WIDTH-1:BL]};
      neg2  <= neg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum  <= (PW'(pp_hh) << (AL + BL)) + (PW'(pp_lh) << BL)
            + (PW'(pp_hl) << AL) + PW'(pp_ll);
      neg3 <= neg2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p <= neg3 ? (~sum + PW'(1)) : sum;
    end
  end

endmodule
`default_nettype wire

### sv/ppct_cfg.sv
`default_nettype none
module ppct_cfg #(
  parameter int COORD_WIDTH = ppct_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ppct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  output logic signed [COORD_WIDTH-1:0]     bottom_x,
  output logic signed [COORD_WIDTH-1:0]     bottom_y,
  output logic signed [COORD_WIDTH-1:0]     bottom_z,
  output logic signed [COORD_WIDTH:0]       axis_x,
  output logic signed [COORD_WIDTH:0]       axis_y,
  output logic signed [COORD_WIDTH:0]       axis_z,
  output logic [COORD_WIDTH-2:0]            radius,
  output logic [COORD_WIDTH+1:0]            axis_len,
  output logic [2*COORD_WIDTH+3:0]          axis_len_sq,
  output ppct_pkg::ppct_status_t            status
);
  import ppct_pkg::*;

  localparam int CW    = COORD_WIDTH + 1;
  localparam int LW    = COORD_WIDTH + 2;
  localparam int L2W   = 2 * LW;
  localparam int RW    = LW + 2;
  localparam int CNT_W = $clog2(LW);
  localparam int DSQ_W = 2 * CW;

  cfg_state_t                    state;
  cfg_state_t                    state_next;
  logic signed [COORD_WIDTH-1:0] top_x;
  logic signed [COORD_WIDTH-1:0] top_y;
  logic signed [COORD_WIDTH-1:0] top_z;
  logic [CNT_W-1:0]              cnt;
  logic [L2W-1:0]                l2;
  logic [L2W-1:0]                rad;
  logic [RW-1:0]                 rem;
  logic [RW-1:0]                 rem_sh;
  logic [RW-1:0]                 trial;
  logic [LW-1:0]                 root;
  logic signed [CW-1:0]          d_sel;
  logic signed [DSQ_W-1:0]       d_sq;
  logic                          reg_write;
  logic                          last_term;
  logic                          last_bit;

  assign reg_write = cfg_we && (cfg_index <= CFG_IDX_W'(REG_RADIUS));
  assign last_term = (cnt == CNT_W'(2));
  assign last_bit  = (cnt == CNT_W'(LW - 1));

  always_comb begin
    priority if (cnt == CNT_W'(0)) begin
      d_sel = axis_x;
    end else if (cnt == CNT_W'(1)) begin
      d_sel = axis_y;
    end else begin
      d_sel = axis_z;
    end
  end

  assign d_sq   = DSQ_W'(d_sel) * DSQ_W'(d_sel);
  assign rem_sh = {rem[RW-3:0], rad[L2W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CFG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CFG_IDLE: state_next = CFG_IDLE;
      CFG_DIFF: state_next = CFG_SQ;
      CFG_SQ: begin
        if (last_term) state_next = CFG_ROOT;
      end
      CFG_ROOT: begin
        if (last_bit) state_next = CFG_LSQ;
      end
      CFG_LSQ:  state_next = CFG_IDLE;
      default:  state_next = CFG_IDLE;
    endcase
    // any register write restarts the axis computation
    if (reg_write) state_next = CFG_DIFF;
    status.busy       = (state != CFG_IDLE) || cfg_we;
    status.degenerate = (axis_len == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_x    <= '0;
      bottom_y    <= '0;
      bottom_z    <= '0;
      top_x       <= '0;
      top_y       <= '0;
      top_z       <= '0;
      radius      <= '0;
      axis_x      <= '0;
      axis_y      <= '0;
      axis_z      <= '0;
      axis_len    <= '0;
      axis_len_sq <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOTTOM_X: bottom_x <= cfg_data;
          REG_BOTTOM_Y: bottom_y <= cfg_data;
          REG_BOTTOM_Z: bottom_z <= cfg_data;
          REG_TOP_X:    top_x    <= cfg_data;
          REG_TOP_Y:    top_y    <= cfg_data;
          REG_TOP_Z:    top_z    <= cfg_data;
          REG_RADIUS:   radius   <= cfg_data[COORD_WIDTH-2:0];
          default: ;
        endcase
      end
      unique case (state)
        CFG_DIFF: begin
          axis_x <= CW'(top_x) - CW'(bottom_x);
          axis_y <= CW'(top_y) - CW'(bottom_y);
          axis_z <= CW'(top_z) - CW'(bottom_z);
          cnt    <= '0;
          l2     <= '0;
        end
        CFG_SQ: begin
          l2 <= l2 + L2W'($unsigned(d_sq));
          if (last_term) begin
            rad  <= l2 + L2W'($unsigned(d_sq));
            rem  <= '0;
            root <= '0;
            cnt  <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        CFG_ROOT: begin
          // one root bit per cycle, two radicand bits shifted in
          rad <= {rad[L2W-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[LW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[LW-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
        end
        CFG_LSQ: begin
          axis_len    <= root;
          axis_len_sq <= {{LW{1'b0}}, root} * {{LW{1'b0}}, root};
        end
        default: ;
      endcase
    end
  end

  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    reg_write |=> state == CFG_DIFF)
    else $error("register write did not restart axis computation");

  a_len_stable_idle: assert property (@(posedge clk) disable iff (rst)
    state == CFG_IDLE && !cfg_we |=> $stable(axis_len) && $stable(axis_len_sq))
    else $error("axis length changed while idle");

  a_sq_count: assert property (@(posedge clk) disable iff (rst)
    state == CFG_SQ |-> cnt <= CNT_W'(2))
    else $error("squared length term count out of range");

endmodule
`default_nettype wire

### sv/point_in_padded_cylinder_test_core.sv
// Padded point-in-cylinder test.
// Configuration: write cfg_data to register cfg_index with cfg_we high; indexes
// 0..2 bottom center x/y/z, 3..5 top center x/y/z, 6 radius. Each write starts
// the axis unit, which forms the axis vector, its squared length, a bit-serial
// integer square root (one bit a cycle) and the squared root. point_ch.ready
// stays low from a write, the write cycle included, until the axis unit is
// idle again.
// Items: point_ch carries a point and a pad, result_ch one result per item,
// inside_res and degenerate_axis. An item is taken whenever valid and ready
// are both high.
// Throughput is one item per cycle while result_ch.ready is high and the axis
// unit is idle. An item passes an input subtract stage, two four-stage split
// multipliers in series with a sum stage after each, and the output register.
// When result_ch.ready is low the output register holds its item and the
// stages behind it keep filling until each holds an item; only then does
// point_ch.ready fall. Nothing is dropped or repeated.
// Reset zeroes the configuration and axis registers and empties the pipeline;
// with a zero axis every item returns degenerate_axis set and inside_res clear.
`default_nettype none
module point_in_padded_cylinder_test_core #(
  parameter int COORD_WIDTH = ppct_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data,
  ppct_point_if.sink                      point_ch,
  ppct_result_if.source                   result_ch
);
  import ppct_pkg::*;

  localparam int CW      = COORD_WIDTH + 1;
  localparam int LW      = COORD_WIDTH + 2;
  localparam int RPW     = COORD_WIDTH + 1;
  localparam int PW      = 2 * CW;
  localparam int PLW     = COORD_WIDTH + LW + 1;
  localparam int RSW     = 2 * RPW;
  localparam int PJW     = PW + 2;
  localparam int CXW     = PW + 1;
  localparam int HIW     = 2 * LW + 2;
  localparam int SQW     = 2 * CXW;
  localparam int CSW     = SQW + 2;
  localparam int RHW     = RSW + 2 * LW;
  localparam int N_M1    = 9;
  localparam int ST_M1   = 1;
  localparam int ST_SUM1 = ST_M1 + MUL_STAGES;
  localparam int ST_M2   = ST_SUM1 + 1;
  localparam int ST_SUM2 = ST_M2 + MUL_STAGES;
  localparam int ST_OUT  = ST_SUM2 + 1;
  localparam int NS      = ST_OUT + 1;

  logic signed [COORD_WIDTH-1:0] bottom_x;
  logic signed [COORD_WIDTH-1:0] bottom_y;
  logic signed [COORD_WIDTH-1:0] bottom_z;
  logic signed [CW-1:0]          axis_x;
  logic signed [CW-1:0]          axis_y;
  logic signed [CW-1:0]          axis_z;
  logic [COORD_WIDTH-2:0]        radius;
  logic [LW-1:0]                 axis_len;
  logic [2*LW-1:0]               axis_len_sq;
  ppct_status_t                  status;

  logic [NS-1:0]                 v;
  logic [NS-1:0]                 en;

  logic signed [CW-1:0]          a_x;
  logic signed [CW-1:0]          a_y;
  logic signed [CW-1:0]          a_z;
  logic signed [COORD_WIDTH-1:0] pad;
  logic signed [RPW-1:0]         rp_in;
  logic signed [RPW-1:0]         rp;

  logic [CW-1:0]                 m1_a [N_M1];
  logic [CW-1:0]                 m1_b [N_M1];
  logic [PW-1:0]                 m1_p [N_M1];
  logic [PLW-1:0]                padlen_p;
  logic [RSW-1:0]                rpsq_p;

  logic signed [PJW-1:0]         proj;
  logic signed [CXW-1:0]         cx;
  logic signed [CXW-1:0]         cy;
  logic signed [CXW-1:0]         cz;
  logic signed [PLW-1:0]         padlen;
  logic signed [HIW-1:0]         hi;
  logic [RSW-1:0]                rpsq;
  logic                          axial_ok;

  logic [SQW-1:0]                sq_x;
  logic [SQW-1:0]                sq_y;
  logic [SQW-1:0]                sq_z;
  logic [RHW-1:0]                rhs_p;
  logic [CSW-1:0]                cs;
  logic [RHW-1:0]                rhs;

  logic [ST_SUM2:0]              kill;
  logic [ST_SUM2:0]              degen;
  logic                          inside_o;
  logic                          degen_o;

  ppct_cfg #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .bottom_x    (bottom_x),
    .bottom_y    (bottom_y),
    .bottom_z    (bottom_z),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .radius      (radius),
    .axis_len    (axis_len),
    .axis_len_sq (axis_len_sq),
    .status      (status)
  );

  // a stage advances when empty or when the stage after it advances
  always_comb begin
    en[NS-1] = !v[NS-1] || result_ch.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign point_ch.ready = en[0] && !status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= point_ch.valid && !status.busy;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // offset from bottom center and radius minus pad
  assign rp_in = $signed({2'b00, radius}) - RPW'(point_ch.pad_distance);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_x      <= CW'(point_ch.point_x) - CW'(bottom_x);
      a_y      <= CW'(point_ch.point_y) - CW'(bottom_y);
      a_z      <= CW'(point_ch.point_z) - CW'(bottom_z);
      pad      <= point_ch.pad_distance;
      rp       <= rp_in;
    end
  end

  // dot product terms, then the cross product term pairs
  always_comb begin
    m1_a[0] = a_x;  m1_b[0] = axis_x;
    m1_a[1] = a_y;  m1_b[1] = axis_y;
    m1_a[2] = a_z;  m1_b[2] = axis_z;
    m1_a[3] = a_y;  m1_b[3] = axis_z;
    m1_a[4] = a_z;  m1_b[4] = axis_y;
    m1_a[5] = a_z;  m1_b[5] = axis_x;
    m1_a[6] = a_x;  m1_b[6] = axis_z;
    m1_a[7] = a_x;  m1_b[7] = axis_y;
    m1_a[8] = a_y;  m1_b[8] = axis_x;
  end

  for (genvar k = 0; k < N_M1; k++) begin : g_m1
    ppct_mul #(
      .A_WIDTH    (CW),
      .B_WIDTH    (CW),
      .SIGNED_OPS (1'b1)
    ) u_mul (
      .clk (clk),
      .en  (en[ST_M1 +: MUL_STAGES]),
      .a   (m1_a[k]),
      .b   (m1_b[k]),
      .p   (m1_p[k])
    );
  end

  ppct_mul #(
    .A_WIDTH    (COORD_WIDTH),
    .B_WIDTH    (LW + 1),
    .SIGNED_OPS (1'b1)
  ) u_mul_padlen (
    .clk (clk),
    .en  (en[ST_M1 +: MUL_STAGES]),
    .a   (pad),
    .b   ({1'b0, axis_len}),
    .p   (padlen_p)
  );

  ppct_mul #(
    .A_WIDTH    (RPW),
    .B_WIDTH    (RPW),
    .SIGNED_OPS (1'b1)
  ) u_mul_rpsq (
    .clk (clk),
    .en  (en[ST_M1 +: MUL_STAGES]),
    .a   (rp),
    .b   (rp),
    .p   (rpsq_p)
  );

  always_ff @(posedge clk) begin
    if (en[ST_SUM1]) begin
      proj   <= PJW'($signed(m1_p[0])) + PJW'($signed(m1_p[1]))
              + PJW'($signed(m1_p[2]));
      cx     <= CXW'($signed(m1_p[3])) - CXW'($signed(m1_p[4]));
      cy     <= CXW'($signed(m1_p[5])) - CXW'($signed(m1_p[6]));
      cz     <= CXW'($signed(m1_p[7])) - CXW'($signed(m1_p[8]));
      padlen <= $signed(padlen_p);
      hi     <= $signed({2'b00, axis_len_sq}) - HIW'($signed(padlen_p));
      rpsq   <= rpsq_p;
    end
  end

  // pad*len <= a.d <= len*len - pad*len
  assign axial_ok = (HIW'(proj) >= HIW'(padlen)) && (HIW'(proj) <= hi);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kill[0]  <= rp_in[RPW-1];
      degen[0] <= status.degenerate;
    end
    for (int i = 1; i <= ST_SUM2; i++) begin
      if (en[i]) begin
        kill[i]  <= (i == ST_M2) ? (kill[i-1] || !axial_ok) : kill[i-1];
        degen[i] <= degen[i-1];
      end
    end
  end

  ppct_mul #(
    .A_WIDTH    (CXW),
    .B_WIDTH    (CXW),
    .SIGNED_OPS (1'b1)
  ) u_mul_sqx (
    .clk (clk),
    .en  (en[ST_M2 +: MUL_STAGES]),
    .a   (cx),
    .b   (cx),
    .p   (sq_x)
  );

  ppct_mul #(
    .A_WIDTH    (CXW),
    .B_WIDTH    (CXW),
    .SIGNED_OPS (1'b1)
  ) u_mul_sqy (
    .clk (clk),
    .en  (en[ST_M2 +: MUL_STAGES]),
    .a   (cy),
    .b   (cy),
    .p   (sq_y)
  );

  ppct_mul #(
    .A_WIDTH    (CXW),
    .B_WIDTH    (CXW),
    .SIGNED_OPS (1'b1)
  ) u_mul_sqz (
    .clk (clk),
    .en  (en[ST_M2 +: MUL_STAGES]),
    .a   (cz),
    .b   (cz),
    .p   (sq_z)
  );

  ppct_mul #(
    .A_WIDTH    (RSW),
    .B_WIDTH    (2 * LW),
    .SIGNED_OPS (1'b0)
  ) u_mul_rhs (
    .clk (clk),
    .en  (en[ST_M2 +: MUL_STAGES]),
    .a   (rpsq),
    .b   (axis_len_sq),
    .p   (rhs_p)
  );

  always_ff @(posedge clk) begin
    if (en[ST_SUM2]) begin
      cs  <= CSW'(sq_x) + CSW'(sq_y) + CSW'(sq_z);
      rhs <= rhs_p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      inside_o <= !kill[ST_SUM2] && !degen[ST_SUM2] && (cs <= CSW'(rhs));
      degen_o  <= degen[ST_SUM2];
    end
  end

  assign result_ch.valid           = v[ST_OUT];
  assign result_ch.inside_res      = inside_o;
  assign result_ch.degenerate_axis = degen_o;

  a_degen_outside: assert property (@(posedge clk) disable iff (rst)
    v[ST_OUT] && degen_o |-> !inside_o)
    else $error("degenerate axis item reported inside");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    v[ST_OUT] && !result_ch.ready |=> v[ST_OUT] && $stable(inside_o) && $stable(degen_o))
    else $error("stalled result item changed");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    point_ch.valid && point_ch.ready |=> v[0])
    else $error("accepted item did not enter the pipeline");

endmodule
`default_nettype wire
